@@ rtl/core/sorted_checkpoint_table_macros.svh @@
// ----------------------------------------------------------------------------
// sorted_checkpoint_table_macros.svh
// Assertion macros used by the checkpoint table RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_CHECKPOINT_TABLE_MACROS_SVH
`define SORTED_CHECKPOINT_TABLE_MACROS_SVH

// Property checked at every clock edge outside reset.
`define SCT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/sct_pkg.sv @@
// ----------------------------------------------------------------------------
// sct_pkg
// Types and constants of the sorted checkpoint table.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int TEAM_SLOTS  = 16;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int GRP_SIZE    = 8;
    localparam int GRP_NUM     = (TABLE_DEPTH + GRP_SIZE - 1) / GRP_SIZE;

    localparam int IN_TDATA_W  = 208;
    localparam int OUT_TDATA_W = 216;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_NEXT  = 2'd1;
    localparam logic [1:0] ACT_PREV  = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STS_DUPLICATE = 2'd2;
    localparam logic [1:0] STS_FULL      = 2'd3;

    function automatic logic [63:0] team_mask(input int base);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (base + b < TEAM_SLOTS) begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    localparam logic [63:0] TEAM_MASK_LO = team_mask(0);
    localparam logic [63:0] TEAM_MASK_HI = team_mask(8);

    typedef struct packed {
        logic [63:0] teams_hi;
        logic [63:0] teams_lo;
        logic [7:0]  key;
        logic [31:0] pos;
        logic [31:0] time_val;
    } entry_t;

    typedef struct packed {
        logic [1:0]  action;
        entry_t      ent;
    } req_t;

    typedef struct packed {
        logic cmp_en;
        logic occ;
        logic ld_left;
        logic ld_new;
    } cell_ctl_t;

    typedef struct packed {
        logic gt;
        logic eq;
        logic lt;
    } cmp_t;

endpackage

@@ rtl/core/sorted_checkpoint_table.sv @@
// ----------------------------------------------------------------------------
// sorted_checkpoint_table
// Time-sorted checkpoint table with insert, next/prev search and clear.
// ----------------------------------------------------------------------------
// A request passes through the states S_CMP, S_SEL and S_FIN after the
// accepting edge captures it: S_CMP runs a parallel compare in every cell of
// the chain, S_SEL the insert shift plus group select, and S_FIN the final
// select. One request is in flight at a time; a new request is taken while
// the previous result still waits on m_tvalid, and it holds in S_FIN until
// that result has been taken. Entries live in a row of TABLE_DEPTH cells
// kept sorted by time; an insert moves every later entry one cell to the
// right in the same cycle. Cells at or above the entry count are unused and
// never read.
// ----------------------------------------------------------------------------
`include "sorted_checkpoint_table_macros.svh"

module sorted_checkpoint_table (
    input  logic                                aclk,
    input  logic                                aresetn,
    // action, query_time, file_pos, key_byte, teams_low, teams_high
    input  logic [sct_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // status, found_time, found_pos, found_key, found_teams_low,
    // found_teams_high, entry_count
    output logic [sct_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready
);
    import sct_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_SEL  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]             state_reg, state_next;
    req_t                   req_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [1:0]             status_reg;
    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    entry_t                 cell_ent [TABLE_DEPTH];
    cmp_t                   cell_cmp [TABLE_DEPTH];
    cell_ctl_t              cell_ctl [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] occ, gt, eq, lt, k_open, nxt_hit, prv_hit, hit;

    entry_t                 pad_ent [GRP_NUM*GRP_SIZE];
    logic [GRP_NUM*GRP_SIZE-1:0] pad_hit;
    entry_t                 grp_ent [GRP_NUM];
    entry_t                 final_ent;
    entry_t                 new_ent;

    logic accept, out_free, dup, full, ins, in_sel;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign in_sel   = (state_reg == S_SEL);

    assign dup  = |eq;
    assign full = (count_reg >= CNT_W'(TABLE_DEPTH));
    assign ins  = in_sel && (req_reg.action == ACT_ADD) && !dup && !full;

    assign new_ent.time_val = req_reg.ent.time_val;
    assign new_ent.pos      = req_reg.ent.pos;
    assign new_ent.key      = req_reg.ent.key;
    assign new_ent.teams_lo = req_reg.ent.teams_lo & TEAM_MASK_LO;
    assign new_ent.teams_hi = req_reg.ent.teams_hi & TEAM_MASK_HI;

    // cell chain
    genvar i;
    generate
        for (i = 0; i < TABLE_DEPTH; i++) begin : g_cell
            assign occ[i]    = (CNT_W'(i) < count_reg);
            assign gt[i]     = cell_cmp[i].gt;
            assign eq[i]     = cell_cmp[i].eq;
            assign lt[i]     = cell_cmp[i].lt;
            assign k_open[i] = gt[i] || !occ[i];

            if (i == 0) begin : g_first
                assign cell_ctl[i].ld_left = 1'b0;
                assign cell_ctl[i].ld_new  = ins && k_open[i];
                assign nxt_hit[i]          = gt[i];
            end else begin : g_rest
                assign cell_ctl[i].ld_left = ins && gt[i-1];
                assign cell_ctl[i].ld_new  = ins && k_open[i] && !k_open[i-1];
                assign nxt_hit[i]          = gt[i] && !gt[i-1];
            end

            if (i == TABLE_DEPTH - 1) begin : g_last
                assign prv_hit[i] = lt[i];
            end else begin : g_mid
                assign prv_hit[i] = lt[i] && !lt[i+1];
            end

            assign cell_ctl[i].cmp_en = (state_reg == S_CMP);
            assign cell_ctl[i].occ    = occ[i];

            sct_cell u_cell (
                .aclk       (aclk),
                .ctl        (cell_ctl[i]),
                .query_time (req_reg.ent.time_val),
                .left_ent   ((i == 0) ? new_ent : cell_ent[(i == 0) ? 0 : i-1]),
                .new_ent    (new_ent),
                .ent        (cell_ent[i]),
                .cmp        (cell_cmp[i])
            );
        end
    endgenerate

    assign hit = (req_reg.action == ACT_NEXT) ? nxt_hit :
                 (req_reg.action == ACT_PREV) ? prv_hit : '0;

    // grouped select
    genvar p, g;
    generate
        for (p = 0; p < GRP_NUM*GRP_SIZE; p++) begin : g_pad
            if (p < TABLE_DEPTH) begin : g_real
                assign pad_ent[p] = cell_ent[p];
                assign pad_hit[p] = hit[p];
            end else begin : g_fill
                assign pad_ent[p] = '0;
                assign pad_hit[p] = 1'b0;
            end
        end
        for (g = 0; g < GRP_NUM; g++) begin : g_grp
            sct_merge u_merge (
                .aclk   (aclk),
                .en     (in_sel),
                .hit    (pad_hit[g*GRP_SIZE +: GRP_SIZE]),
                .ents   (pad_ent[g*GRP_SIZE +: GRP_SIZE]),
                .merged (grp_ent[g])
            );
        end
    endgenerate

    always_comb begin
        final_ent = '0;
        for (int n = 0; n < GRP_NUM; n++) begin
            final_ent = final_ent | grp_ent[n];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept)   state_next = S_CMP;
            S_CMP:                state_next = S_SEL;
            S_SEL:                state_next = S_FIN;
            S_FIN:  if (out_free) state_next = S_IDLE;
            default:              state_next = S_IDLE;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (in_sel && (req_reg.action == ACT_CLEAR)) begin
            count_next = '0;
        end else if (ins) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if ((state_reg == S_FIN) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg.action       <= s_tdata[1:0];
            req_reg.ent.time_val <= s_tdata[33:2];
            req_reg.ent.pos      <= s_tdata[65:34];
            req_reg.ent.key      <= s_tdata[73:66];
            req_reg.ent.teams_lo <= s_tdata[137:74];
            req_reg.ent.teams_hi <= s_tdata[201:138];
        end
        if (in_sel) begin
            case (req_reg.action)
                ACT_ADD:   status_reg <= dup ? STS_DUPLICATE : (full ? STS_FULL : STS_OK);
                ACT_CLEAR: status_reg <= STS_OK;
                default:   status_reg <= (|hit) ? STS_OK : STS_NOT_FOUND;
            endcase
        end
        if ((state_reg == S_FIN) && out_free) begin
            m_data_reg <= {7'd0,
                           7'(count_reg),
                           final_ent.teams_hi,
                           final_ent.teams_lo,
                           final_ent.key,
                           final_ent.pos,
                           final_ent.time_val,
                           status_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `SCT_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(TABLE_DEPTH),
                "count above depth")
    `SCT_ASSERT(a_hit_onehot, aclk, aresetn, !in_sel || $onehot0(hit),
                "multiple search hits")
    `SCT_ASSERT_NEXT(a_ins_count, aclk, aresetn, ins,
                     count_reg == $past(count_reg) + CNT_W'(1), "insert did not bump count")
    `SCT_ASSERT_NEXT(a_fin_load, aclk, aresetn, (state_reg == S_FIN) && out_free,
                     m_valid_reg, "result not presented")

endmodule

@@ rtl/core/sct_cell.sv @@
// ----------------------------------------------------------------------------
// sct_cell
// One table slot: holds an entry, compares it with the query, shifts right.
// ----------------------------------------------------------------------------
module sct_cell (
    input  logic              aclk,
    input  sct_pkg::cell_ctl_t ctl,
    input  logic [31:0]       query_time,
    input  sct_pkg::entry_t   left_ent,
    input  sct_pkg::entry_t   new_ent,
    output sct_pkg::entry_t   ent,
    output sct_pkg::cmp_t     cmp
);
    import sct_pkg::*;

    entry_t ent_reg;
    cmp_t   cmp_reg;

    always_ff @(posedge aclk) begin
        if (ctl.cmp_en) begin
            cmp_reg.gt <= ctl.occ && (ent_reg.time_val > query_time);
            cmp_reg.eq <= ctl.occ && (ent_reg.time_val == query_time);
            cmp_reg.lt <= ctl.occ && (ent_reg.time_val < query_time);
        end
        if (ctl.ld_left) begin
            ent_reg <= left_ent;
        end else if (ctl.ld_new) begin
            ent_reg <= new_ent;
        end
    end

    assign ent = ent_reg;
    assign cmp = cmp_reg;

endmodule

@@ rtl/core/sct_merge.sv @@
// ----------------------------------------------------------------------------
// sct_merge
// Registered one-hot select of an entry out of a group of cells.
// ----------------------------------------------------------------------------
module sct_merge (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [sct_pkg::GRP_SIZE-1:0]   hit,
    input  sct_pkg::entry_t                ents [sct_pkg::GRP_SIZE],
    output sct_pkg::entry_t                merged
);
    import sct_pkg::*;

    entry_t acc;
    entry_t merged_reg;

    always_comb begin
        acc = '0;
        for (int k = 0; k < GRP_SIZE; k++) begin
            acc = acc | (ents[k] & {$bits(entry_t){hit[k]}});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            merged_reg <= acc;
        end
    end

    assign merged = merged_reg;

endmodule
